// ===== rtl/w15_pkg.sv =====
// shared types and constants of the 15-node wedge shape function unit
`default_nettype none
package w15_pkg;
    localparam int NODE_COUNT  = 15;
    localparam int DIMENSIONS  = 3;
    localparam int IN_W        = 18;
    localparam int OUT_W       = 21;
    localparam int IDX_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;
    localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODE_COUNT - 1);

    // one local point in Q16
    typedef struct packed {
        logic signed [IN_W-1:0] xi;
        logic signed [IN_W-1:0] eta;
        logic signed [IN_W-1:0] zeta;
    } t_point;

    // queue head as seen by the evaluator
    typedef struct packed {
        logic   valid;
        t_point point;
    } t_head;
endpackage
`default_nettype wire

// ===== rtl/wedge15_shape_function_eval_top.sv =====
// top level of the 15-node wedge shape function unit
// points pass the sequencer, stages 0 to 2 and the result registers, one node per cycle
// the single node sequencer steps through all 15 nodes of a point, one node a cycle
// a two-entry point queue takes the next point while a run is in progress
// results are strobed for one cycle; the receiver cannot stall them
// synchronous active-low reset empties the queue and clears the run and strobes
`default_nettype none
module wedge15_shape_function_eval_top import w15_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire logic signed [IN_W-1:0]     i_xi,
    input  wire logic signed [IN_W-1:0]     i_eta,
    input  wire logic signed [IN_W-1:0]     i_zeta,
    output logic                            o_valid,
    output logic [IDX_W-1:0]                o_node_index,
    output logic signed [OUT_W-1:0]         o_shape_value,
    output logic signed [OUT_W-1:0]         o_d_xi,
    output logic signed [OUT_W-1:0]         o_d_eta,
    output logic signed [OUT_W-1:0]         o_d_zeta,
    output logic                            o_last_node
);
    t_point pt;
    t_head  head;
    logic   pop;

    assign pt.xi   = i_xi;
    assign pt.eta  = i_eta;
    assign pt.zeta = i_zeta;

    // point queue
    w15_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_point (pt),
        .i_pop   (pop),
        .o_head  (head),
        .o_busy  (o_busy)
    );

    // evaluator
    w15_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_node_index  (o_node_index),
        .o_shape_value (o_shape_value),
        .o_d_xi        (o_d_xi),
        .o_d_eta       (o_d_eta),
        .o_d_zeta      (o_d_zeta),
        .o_last_node   (o_last_node)
    );

    // the last flag marks node 14 only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_node == (o_node_index == LAST_NODE)))
        else $error("last flag on wrong node");

    // a run is delivered without gaps in node order
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_node) |=>
            (o_valid && o_node_index == $past(o_node_index) + 1'b1))
        else $error("node sequence broken");

    // a run always opens at node 0
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_node_index == '0))
        else $error("run did not start at node 0");
endmodule
`default_nettype wire

// ===== rtl/w15_front.sv =====
// input acceptance and point queue
`default_nettype none
module w15_front import w15_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_point i_point,
    input  wire logic   i_pop,
    output t_head       o_head,
    output logic        o_busy
);
    t_point             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               push, pop;

    assign o_busy = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.point = r_q[r_rp];

    // pointer and fill count update
    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_point;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/w15_back.sv =====
// node sequencer and shape function product pipeline
`default_nettype none
module w15_back import w15_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_head                   i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    output logic [IDX_W-1:0]             o_node_index,
    output logic signed [OUT_W-1:0]      o_shape_value,
    output logic signed [OUT_W-1:0]      o_d_xi,
    output logic signed [OUT_W-1:0]      o_d_eta,
    output logic signed [OUT_W-1:0]      o_d_zeta,
    output logic                         o_last_node
);
    localparam int TW   = 23;
    localparam int CW   = TW + 3;
    localparam int ABW  = 2 * TW;
    localparam int HALF = TW;
    localparam int SW   = ABW + CW;
    localparam int LANES = DIMENSIONS + 1;
    localparam logic signed [TW-1:0] ONE = TW'(65536);
    localparam logic signed [SW-1:0] RND = SW'(64'h1_0000_0000);
    localparam logic signed [SW-34:0] SAT_MAX = (SW-33)'(1048575);
    localparam logic signed [SW-34:0] SAT_MIN = -(SW-33)'(1048576);

    typedef enum logic [3:0] {
        T_ZERO, T_ONE, T_X, T_E, T_Z, T_L, T_U, T_W,
        T_LX, T_LE, T_C, T_F, T_G, T_D, T_H
    } t_term;

    typedef struct packed {
        t_term       a;
        t_term       b;
        t_term       c;
        logic        neg;
        logic [1:0]  sh;
    } t_op;

    typedef struct packed {
        logic signed [TW-1:0] x, e, z, l, u, w, lx, le, c, f, g, d, h;
    } t_terms;

    function automatic t_op mk(input t_term a, input t_term b, input t_term c,
                               input logic neg, input logic [1:0] sh);
        t_op o;
        o.a = a; o.b = b; o.c = c; o.neg = neg; o.sh = sh;
        return o;
    endfunction

    // factor selection for each node and output lane
    function automatic t_op sel(input logic [IDX_W-1:0] k, input logic [1:0] d,
                                input logic [1:0] kc);
        t_op z0;
        t_op o;
        z0 = mk(T_ZERO, T_ZERO, T_ZERO, 1'b0, 2'd0);
        o  = z0;
        priority if (k < IDX_W'(6)) begin
            unique case (d)
                2'd0: o = mk(T_C, T_F, T_G, 1'b0, 2'd0);
                2'd1: o = (kc == 2'd0) ? mk(T_F, T_D, T_ONE, 1'b1, 2'd0) :
                          (kc == 2'd1) ? mk(T_F, T_D, T_ONE, 1'b0, 2'd0) : z0;
                2'd2: o = (kc == 2'd0) ? mk(T_F, T_D, T_ONE, 1'b1, 2'd0) :
                          (kc == 2'd2) ? mk(T_F, T_D, T_ONE, 1'b0, 2'd0) : z0;
                2'd3: o = mk(T_C, T_H, T_ONE, k < IDX_W'(3), 2'd0);
            endcase
        end else begin
            unique case (k)
                IDX_W'(6), IDX_W'(9): begin
                    unique case (d)
                        2'd0: o = mk(T_X, T_L, (k == IDX_W'(6)) ? T_U : T_W, 1'b0, 2'd2);
                        2'd1: o = mk((k == IDX_W'(6)) ? T_U : T_W, T_LX, T_ONE, 1'b0, 2'd2);
                        2'd2: o = mk(T_X, (k == IDX_W'(6)) ? T_U : T_W, T_ONE, 1'b1, 2'd2);
                        2'd3: o = mk(T_X, T_L, T_ONE, k == IDX_W'(6), 2'd2);
                    endcase
                end
                IDX_W'(7), IDX_W'(10): begin
                    unique case (d)
                        2'd0: o = mk(T_X, T_E, (k == IDX_W'(7)) ? T_U : T_W, 1'b0, 2'd2);
                        2'd1: o = mk(T_E, (k == IDX_W'(7)) ? T_U : T_W, T_ONE, 1'b0, 2'd2);
                        2'd2: o = mk(T_X, (k == IDX_W'(7)) ? T_U : T_W, T_ONE, 1'b0, 2'd2);
                        2'd3: o = mk(T_X, T_E, T_ONE, k == IDX_W'(7), 2'd2);
                    endcase
                end
                IDX_W'(8), IDX_W'(11): begin
                    unique case (d)
                        2'd0: o = mk(T_E, T_L, (k == IDX_W'(8)) ? T_U : T_W, 1'b0, 2'd2);
                        2'd1: o = mk(T_E, (k == IDX_W'(8)) ? T_U : T_W, T_ONE, 1'b1, 2'd2);
                        2'd2: o = mk((k == IDX_W'(8)) ? T_U : T_W, T_LE, T_ONE, 1'b0, 2'd2);
                        2'd3: o = mk(T_E, T_L, T_ONE, k == IDX_W'(8), 2'd2);
                    endcase
                end
                IDX_W'(12): begin
                    unique case (d)
                        2'd0: o = mk(T_L, T_U, T_W, 1'b0, 2'd1);
                        2'd1: o = mk(T_U, T_W, T_ONE, 1'b1, 2'd1);
                        2'd2: o = mk(T_U, T_W, T_ONE, 1'b1, 2'd1);
                        2'd3: o = mk(T_Z, T_L, T_ONE, 1'b1, 2'd2);
                    endcase
                end
                IDX_W'(13): begin
                    unique case (d)
                        2'd0: o = mk(T_X, T_U, T_W, 1'b0, 2'd1);
                        2'd1: o = mk(T_U, T_W, T_ONE, 1'b0, 2'd1);
                        2'd2: o = z0;
                        2'd3: o = mk(T_X, T_Z, T_ONE, 1'b1, 2'd2);
                    endcase
                end
                IDX_W'(14): begin
                    unique case (d)
                        2'd0: o = mk(T_E, T_U, T_W, 1'b0, 2'd1);
                        2'd1: o = z0;
                        2'd2: o = mk(T_U, T_W, T_ONE, 1'b0, 2'd1);
                        2'd3: o = mk(T_E, T_Z, T_ONE, 1'b1, 2'd2);
                    endcase
                end
                default: o = z0;
            endcase
        end
        return o;
    endfunction

    function automatic logic signed [TW-1:0] tval(input t_term code, input t_terms t);
        logic signed [TW-1:0] v;
        unique case (code)
            T_ZERO: v = '0;
            T_ONE:  v = ONE;
            T_X:    v = t.x;
            T_E:    v = t.e;
            T_Z:    v = t.z;
            T_L:    v = t.l;
            T_U:    v = t.u;
            T_W:    v = t.w;
            T_LX:   v = t.lx;
            T_LE:   v = t.le;
            T_C:    v = t.c;
            T_F:    v = t.f;
            T_G:    v = t.g;
            T_D:    v = t.d;
            T_H:    v = t.h;
        endcase
        return v;
    endfunction

    // node sequencer
    t_point            r_pt;
    logic              r_run;
    logic [IDX_W-1:0]  r_k;

    assign o_pop = i_head.valid && (!r_run || r_k == LAST_NODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_k   <= '0;
        end else if (o_pop) begin
            r_run <= 1'b1;
            r_k   <= '0;
        end else if (r_run) begin
            r_run <= (r_k != LAST_NODE);
            r_k   <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pt <= i_head.point;
        end
    end

    // linear terms of the current node
    t_terms           tm;
    logic [1:0]       kc;
    logic signed [TW-1:0] zt;

    always_comb begin
        kc   = (r_k >= IDX_W'(3)) ? 2'(r_k - IDX_W'(3)) : r_k[1:0];
        tm.x = TW'(r_pt.xi);
        tm.e = TW'(r_pt.eta);
        tm.z = TW'(r_pt.zeta);
        tm.l = ONE - tm.x - tm.e;
        tm.u = ONE - tm.z;
        tm.w = ONE + tm.z;
        tm.lx = tm.l - tm.x;
        tm.le = tm.l - tm.e;
        tm.c = (kc == 2'd0) ? tm.l : (kc == 2'd1) ? tm.x : tm.e;
        tm.f = (r_k < IDX_W'(3)) ? tm.u : tm.w;
        zt   = (r_k < IDX_W'(3)) ? -tm.z : tm.z;
        tm.g = (tm.c <<< 1) + zt - (ONE <<< 1);
        tm.d = (tm.c <<< 2) + zt - (ONE <<< 1);
        tm.h = (tm.c <<< 1) + (zt <<< 1) - ONE;
    end

    // stage 0: operand select, scale folded into third factor
    logic signed [TW-1:0]  r_a [LANES];
    logic signed [TW-1:0]  r_b [LANES];
    logic signed [CW-1:0]  r_c0 [LANES];
    logic                  r_v0, r_v1, r_v2;
    logic [IDX_W-1:0]      r_k0, r_k1, r_k2;

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < LANES; d++) begin
            t_op                  op;
            logic signed [CW-1:0] cs;
            op = sel(r_k, 2'(d), kc);
            cs = CW'(tval(op.c, tm)) <<< op.sh;
            r_a[d]  <= tval(op.a, tm);
            r_b[d]  <= tval(op.b, tm);
            r_c0[d] <= op.neg ? -cs : cs;
        end
        r_k0 <= r_k;
    end

    // stage 1: first product
    logic signed [ABW-1:0] r_ab [LANES];
    logic signed [CW-1:0]  r_c1 [LANES];

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < LANES; d++) begin
            r_ab[d] <= r_a[d] * r_b[d];
            r_c1[d] <= r_c0[d];
        end
        r_k1 <= r_k0;
    end

    // stage 2: split partial products by the third factor
    logic signed [HALF+CW-1:0]   r_hi [LANES];
    logic signed [HALF+CW:0]     r_lo [LANES];

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < LANES; d++) begin
            r_hi[d] <= $signed(r_ab[d][ABW-1:HALF]) * r_c1[d];
            r_lo[d] <= $signed({1'b0, r_ab[d][HALF-1:0]}) * r_c1[d];
        end
        r_k2 <= r_k1;
    end

    // stage 3: recombine, round half up to Q16, saturate
    logic signed [OUT_W-1:0] res [LANES];

    always_comb begin
        for (int d = 0; d < LANES; d++) begin
            logic signed [SW-1:0]    s;
            logic signed [SW-34:0]   q;
            s = (SW'(r_hi[d]) <<< HALF) + SW'(r_lo[d]) + RND;
            q = s[SW-1:33];
            if (q > SAT_MAX) begin
                res[d] = OUT_W'(SAT_MAX);
            end else if (q < SAT_MIN) begin
                res[d] = OUT_W'(SAT_MIN);
            end else begin
                res[d] = OUT_W'(q);
            end
        end
    end

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v0    <= r_run;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        o_node_index  <= r_k2;
        o_last_node   <= (r_k2 == LAST_NODE);
        o_shape_value <= res[0];
        o_d_xi        <= res[1];
        o_d_eta       <= res[2];
        o_d_zeta      <= res[3];
    end
endmodule
`default_nettype wire
